// ----- rtl/core/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants for the block transposition cipher core.
// ----------------------------------------------------------------------------
package btc_pkg;

	localparam int DATA_W  = 8;   // message byte
	localparam int SIZE_W  = 5;   // block_size register
	localparam int PERM_W  = 4;   // one permutation entry
	localparam int TABLE_W = 64;  // packed permutation table
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 64;

	localparam logic [DATA_W-1:0] PAD_BYTE     = 8'h20;
	localparam logic [DATA_W-1:0] PERCENT_BYTE = 8'h25;

	// register map, byte address = 8 * index
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_SIZE = 2'd1;
	localparam logic [1:0] REG_PERM = 2'd2;

	localparam logic [SIZE_W-1:0]  SIZE_RESET = 5'd16;
	localparam logic [TABLE_W-1:0] PERM_RESET = 64'hFEDC_BA98_7654_3210;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [SIZE_W-1:0]   block_size;
		logic [TABLE_W-1:0]  perm_table;
	} cfg_t;

	// result of one lookup in the shared permutation unit
	typedef struct packed {
		logic [PERM_W-1:0] p;
		logic              in_range;
	} perm_res_t;

	// engine status seen by the top level
	typedef struct packed {
		logic [SIZE_W-1:0] fill;
		logic              busy;
	} eng_status_t;

endpackage

// ----- rtl/core/btc_if.sv -----
// ----------------------------------------------------------------------------
// btc_if
// Valid/ready channel interfaces for message bytes in and cipher bytes out.
// ----------------------------------------------------------------------------
interface btc_in_if;
	logic                         valid;
	logic                         ready;
	logic [btc_pkg::DATA_W-1:0]   in_byte;
	logic                         message_end;

	modport source (output valid, output in_byte, output message_end, input ready);
	modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface btc_out_if;
	logic                         valid;
	logic                         ready;
	logic [btc_pkg::DATA_W-1:0]   out_byte;
	logic                         block_last;
	logic                         message_last;

	modport source (output valid, output out_byte, output block_last,
		output message_last, input ready);
	modport sink   (input valid, input out_byte, input block_last,
		input message_last, output ready);
endinterface

// ----- rtl/core/btc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// btc_cfg_regs
// APB register file: cipher mode, block size and permutation table.
// ----------------------------------------------------------------------------
module btc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btc_pkg::APB_AW-1:0]    paddr,
	input  logic [btc_pkg::APB_DW-1:0]    pwdata,
	output logic [btc_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output btc_pkg::cfg_t                 cfg
);

	btc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:3];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= btc_pkg::MODE_ENC;
			cfg_q.block_size <= btc_pkg::SIZE_RESET;
			cfg_q.perm_table <= btc_pkg::PERM_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				btc_pkg::REG_MODE: cfg_q.mode       <= btc_pkg::mode_t'(pwdata[0]);
				btc_pkg::REG_SIZE: cfg_q.block_size <= pwdata[btc_pkg::SIZE_W-1:0];
				btc_pkg::REG_PERM: cfg_q.perm_table <= pwdata[btc_pkg::TABLE_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			btc_pkg::REG_MODE: prdata = btc_pkg::APB_DW'(cfg_q.mode);
			btc_pkg::REG_SIZE: prdata = btc_pkg::APB_DW'(cfg_q.block_size);
			btc_pkg::REG_PERM: prdata = btc_pkg::APB_DW'(cfg_q.perm_table);
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/btc_perm_unit.sv -----
// ----------------------------------------------------------------------------
// btc_perm_unit
// Shared lookup-and-compare unit: picks one permutation entry and checks it
// against the effective block size.
// ----------------------------------------------------------------------------
module btc_perm_unit (
	input  logic [btc_pkg::PERM_W-1:0]   idx,
	input  logic [btc_pkg::TABLE_W-1:0]  perm_table,
	input  logic [btc_pkg::SIZE_W-1:0]   blk_n,
	output btc_pkg::perm_res_t           res
);

	logic [5:0] bit_pos;

	assign bit_pos      = {idx, 2'b00};
	assign res.p        = perm_table[bit_pos +: btc_pkg::PERM_W];
	assign res.in_range = btc_pkg::SIZE_W'(res.p) < blk_n;

endmodule

// ----- rtl/core/btc_engine.sv -----
// ----------------------------------------------------------------------------
// btc_engine
// Block buffer and sequencer: collects bytes, builds the inverse map for
// decrypt, then walks the block through the shared permutation unit.
// ----------------------------------------------------------------------------
module btc_engine #(
	parameter int MAX_BLOCK = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  btc_pkg::cfg_t                 cfg,
	btc_in_if.sink                        msg_in,
	btc_out_if.source                     blk_out,
	output logic [btc_pkg::PERM_W-1:0]    unit_idx,
	input  btc_pkg::perm_res_t            unit_res,
	output logic [btc_pkg::SIZE_W-1:0]    blk_n,
	output btc_pkg::eng_status_t          status
);

	localparam int IDX_W = $clog2(MAX_BLOCK);
	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

	typedef enum logic [2:0] {
		ST_FILL = 3'b001,
		ST_SCAT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          fill_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      end_q;
	logic [MAX_BLOCK-1:0]      set_q;
	logic [IDX_W-1:0]          inv_q   [MAX_BLOCK];
	logic [btc_pkg::DATA_W-1:0] store_q [MAX_BLOCK];

	logic                      ov_q;
	logic [btc_pkg::DATA_W-1:0] obyte_q;
	logic                      oblk_q;
	logic                      omsg_q;

	logic [btc_pkg::SIZE_W-1:0] n_m1;
	logic                      accept;
	logic                      room;
	logic [CNT_W-1:0]          fill_inc;
	logic                      flush;
	logic [btc_pkg::DATA_W-1:0] wr_byte;
	logic                      idx_last;
	logic [IDX_W-1:0]          p_addr;
	logic                      src_ok;
	logic [IDX_W-1:0]          src_addr;
	logic [btc_pkg::DATA_W-1:0] emit_byte;
	logic                      load;

	// effective block size: zero acts as one, saturate at MAX_BLOCK
	always_comb begin
		if (cfg.block_size == '0) begin
			blk_n = btc_pkg::SIZE_W'(1);
		end else if (cfg.block_size > btc_pkg::SIZE_W'(MAX_BLOCK)) begin
			blk_n = btc_pkg::SIZE_W'(MAX_BLOCK);
		end else begin
			blk_n = cfg.block_size;
		end
	end
	assign n_m1 = blk_n - btc_pkg::SIZE_W'(1);

	// input side
	assign msg_in.ready = (state_q == ST_FILL);
	assign accept       = msg_in.valid && msg_in.ready;
	assign room         = fill_q < MAX_CNT;
	assign fill_inc     = room ? fill_q + CNT_W'(1) : fill_q;
	assign flush        = (btc_pkg::SIZE_W'(fill_inc) >= blk_n) || msg_in.message_end;
	assign wr_byte      = (cfg.mode == btc_pkg::MODE_ENC &&
		msg_in.in_byte == btc_pkg::PERCENT_BYTE) ? btc_pkg::PAD_BYTE : msg_in.in_byte;

	// shared unit is driven by the one position counter
	assign unit_idx = btc_pkg::PERM_W'(idx_q);
	assign idx_last = btc_pkg::SIZE_W'(idx_q) == n_m1;
	assign p_addr   = unit_res.p[IDX_W-1:0];

	// source position for the current output slot; padding past the fill
	always_comb begin
		if (cfg.mode == btc_pkg::MODE_ENC) begin
			src_ok   = unit_res.in_range;
			src_addr = p_addr;
		end else begin
			src_ok   = set_q[idx_q];
			src_addr = inv_q[idx_q];
		end
		emit_byte = (src_ok && (CNT_W'(src_addr) < fill_q)) ? store_q[src_addr]
			: btc_pkg::PAD_BYTE;
	end

	assign load = (state_q == ST_EMIT) && (!ov_q || blk_out.ready);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
			set_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (blk_out.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					if (accept) begin
						fill_q <= fill_inc;
						if (flush) begin
							end_q   <= msg_in.message_end;
							set_q   <= '0;
							idx_q   <= '0;
							state_q <= (cfg.mode == btc_pkg::MODE_ENC) ? ST_EMIT : ST_SCAT;
						end
					end
				end
				ST_SCAT: begin
					if (unit_res.in_range && !set_q[p_addr]) begin
						set_q[p_addr] <= 1'b1;
					end
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (idx_last) begin
							idx_q   <= '0;
							fill_q  <= '0;
							state_q <= ST_FILL;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	// block buffer and inverse map
	always_ff @(posedge clk) begin
		if (accept && room) begin
			store_q[fill_q[IDX_W-1:0]] <= wr_byte;
		end
		if (state_q == ST_SCAT && unit_res.in_range && !set_q[p_addr]) begin
			inv_q[p_addr] <= idx_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= emit_byte;
			oblk_q  <= idx_last;
			omsg_q  <= idx_last && end_q;
		end
	end

	assign blk_out.valid        = ov_q;
	assign blk_out.out_byte     = obyte_q;
	assign blk_out.block_last   = oblk_q;
	assign blk_out.message_last = omsg_q;

	assign status.fill = btc_pkg::SIZE_W'(fill_q);
	assign status.busy = (state_q != ST_FILL);

endmodule

// ----- rtl/core/block_transposition_cipher_core.sv -----
// ----------------------------------------------------------------------------
// block_transposition_cipher_core
// Collects message bytes into blocks and emits each block permuted
// (encrypt) or inverse-permuted (decrypt), one byte per transaction.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// msg_in    in   valid/ready        in_byte[7:0], message_end
// blk_out   out  valid/ready        out_byte[7:0], block_last, message_last
// apb       in   psel/penable/pready pwrite, paddr[4:0], pwdata[63:0] / prdata
//
// A byte that does not close a block is taken while the core fills a block.
// A block of N bytes is then emitted (encrypt), or first walked to build the
// inverse map and then emitted (decrypt), one pass of the shared lookup unit each.
// Input is held off while a block is being mapped or emitted; output stalls
// hold the emit walk. Reset clears the fill count and sequencer; no sweep.
// ----------------------------------------------------------------------------
module block_transposition_cipher_core #(
	parameter int MAX_BLOCK = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	btc_in_if.sink                        msg_in,
	btc_out_if.source                     blk_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btc_pkg::APB_AW-1:0]    paddr,
	input  logic [btc_pkg::APB_DW-1:0]    pwdata,
	output logic [btc_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	btc_pkg::cfg_t               cfg;
	btc_pkg::perm_res_t          unit_res;
	btc_pkg::eng_status_t        status;
	logic [btc_pkg::PERM_W-1:0]  unit_idx;
	logic [btc_pkg::SIZE_W-1:0]  blk_n;

	// configuration registers
	btc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// shared permutation lookup
	btc_perm_unit u_perm (
		.idx        (unit_idx),
		.perm_table (cfg.perm_table),
		.blk_n      (blk_n),
		.res        (unit_res)
	);

	// buffer and sequencer
	btc_engine #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_eng (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.msg_in   (msg_in),
		.blk_out  (blk_out),
		.unit_idx (unit_idx),
		.unit_res (unit_res),
		.blk_n    (blk_n),
		.status   (status)
	);

	// a message end always closes the block and holds off input
	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		msg_in.valid && msg_in.ready && msg_in.message_end |=> !msg_in.ready)
		else $error("message end did not start a flush");

	// message_last only ever marks the end of a block
	a_msg_last_blk: assert property (@(posedge clk) disable iff (!arst_n)
		blk_out.valid && blk_out.message_last |-> blk_out.block_last)
		else $error("message_last without block_last");

	// fill count stays within the buffer
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.fill <= btc_pkg::SIZE_W'(MAX_BLOCK))
		else $error("fill count beyond buffer depth");

	// input is only taken between blocks
	a_busy_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !msg_in.ready)
		else $error("input ready while a block is in flight");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_transposition_cipher_core. A scripted run
// covers register extremes, the percent and padding rules, out-of-range and
// duplicate permutation entries and a size change inside a block. Random
// messages under random settings follow. Every cipher byte is compared
// against an in-bench cipher model.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          MAX_BLOCK   = 16;
	localparam int          DRAIN_GAP   = 40;
	localparam int unsigned LONG_STALL  = 300;
	localparam int unsigned LIMIT       = 400000;
	localparam int          PHASE_BYTES = 64;
	localparam int          MAX_REPORTS = 200;

	// one emitted cipher byte
	typedef struct packed {
		logic [btc_pkg::DATA_W-1:0] data;
		logic                       blk_end;
		logic                       msg_end;
	} cipher_beat_t;

	typedef enum logic {
		ROW_BYTE = 1'b0,
		ROW_REG  = 1'b1
	} row_kind_t;

	// scripted step: a register write or one message byte
	typedef struct packed {
		row_kind_t                  kind;
		logic [1:0]                 reg_idx;
		logic [63:0]                value;
		logic [btc_pkg::DATA_W-1:0] data;
		logic                       last;
		logic                       known;
		logic [4:0]                 known_count;
		logic [btc_pkg::DATA_W-1:0] known_first;
	} script_row_t;

	localparam int SCRIPT_LEN = 34;

	script_row_t script [SCRIPT_LEN] = '{
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h41, 1'b1, 1'b1, 5'd16, 8'h41},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h25, 1'b1, 1'b1, 5'd16, 8'h20},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'hFF, 1'b1, 1'b1, 5'd16, 8'h00},
		'{ROW_REG, btc_pkg::REG_SIZE, 64'd1, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'hFF, 1'b0, 1'b1, 5'd1, 8'hFF},
		'{ROW_REG, btc_pkg::REG_SIZE, 64'd0, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h5A, 1'b0, 1'b1, 5'd1, 8'h5A},
		'{ROW_REG, btc_pkg::REG_SIZE, 64'd31, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h00, 1'b1, 1'b1, 5'd16, 8'h00},
		'{ROW_REG, btc_pkg::REG_SIZE, 64'd4, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_REG, btc_pkg::REG_PERM, 64'hFEDC_BA98_7654_0123,
			8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h31, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h32, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h33, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h34, 1'b0, 1'b1, 5'd4, 8'h34},
		// entry 1 points past the block
		'{ROW_REG, btc_pkg::REG_PERM, 64'hFEDC_BA98_7654_32F0,
			8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h41, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h42, 1'b1, 1'b1, 5'd4, 8'h41},
		'{ROW_REG, btc_pkg::REG_MODE, 64'(btc_pkg::MODE_DEC),
			8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_REG, btc_pkg::REG_PERM, 64'hFEDC_BA98_7654_0123,
			8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h25, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h61, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h62, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h63, 1'b0, 1'b1, 5'd4, 8'h63},
		// duplicate entries, positions 2 and 3 never reached
		'{ROW_REG, btc_pkg::REG_PERM, 64'hFEDC_BA98_7654_1100,
			8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h71, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h72, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h73, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h74, 1'b0, 1'b1, 5'd4, 8'h71},
		// percent kept in decrypt, then mode and size change inside the block
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h25, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_REG, btc_pkg::REG_MODE, 64'(btc_pkg::MODE_ENC),
			8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_REG, btc_pkg::REG_SIZE, 64'd1, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00},
		'{ROW_BYTE, btc_pkg::REG_MODE, 64'd0, 8'h99, 1'b0, 1'b1, 5'd1, 8'h25}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [btc_pkg::APB_AW-1:0]   paddr;
	logic [btc_pkg::APB_DW-1:0]   pwdata;
	logic [btc_pkg::APB_DW-1:0]   prdata;
	logic                         pready;

	btc_in_if  msg_if ();
	btc_out_if cph_if ();

	block_transposition_cipher_core #(
		.MAX_BLOCK (MAX_BLOCK)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg_in  (msg_if),
		.blk_out (cph_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// cipher model state and settings
	btc_pkg::mode_t             key_mode  = btc_pkg::MODE_ENC;
	logic [btc_pkg::SIZE_W-1:0] key_size  = btc_pkg::SIZE_RESET;
	logic [63:0]                key_perm  = btc_pkg::PERM_RESET;
	logic [btc_pkg::DATA_W-1:0] plain_buf [MAX_BLOCK];
	int unsigned                plain_fill = 0;

	cipher_beat_t pending_cipher [$];

	int unsigned errors        = 0;
	int unsigned bytes_sent    = 0;
	int unsigned beats_checked = 0;
	int unsigned reg_writes    = 0;
	int unsigned messages      = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 36;
	int unsigned recv_idle_pct = 77;

	// long output hold request, toggled by stimulus, counted by receiver
	logic        hold_req   = 1'b0;
	logic        hold_ack   = 1'b0;
	int unsigned hold_left  = 0;

	function automatic int unsigned block_len();
		if (key_size == 0) return 1;
		if (key_size > MAX_BLOCK) return MAX_BLOCK;
		return 32'(key_size);
	endfunction

	// take one message byte; queue the cipher bytes of any block it closes
	function automatic int unsigned encipher_step(input logic [btc_pkg::DATA_W-1:0] raw,
			input logic last);
		int unsigned                n, j, p;
		logic [btc_pkg::DATA_W-1:0] b;
		logic [btc_pkg::DATA_W-1:0] blk [MAX_BLOCK];
		bit                         hit [MAX_BLOCK];
		cipher_beat_t               beat;
		n = block_len();
		b = raw;
		if (key_mode == btc_pkg::MODE_ENC && b == btc_pkg::PERCENT_BYTE)
			b = btc_pkg::PAD_BYTE;
		if (plain_fill < MAX_BLOCK) begin
			plain_buf[plain_fill] = b;
			plain_fill++;
		end
		if (plain_fill < n && !last)
			return 0;
		for (j = plain_fill; j < n; j++)
			plain_buf[j] = btc_pkg::PAD_BYTE;
		if (key_mode == btc_pkg::MODE_ENC) begin
			for (j = 0; j < n; j++) begin
				p = 32'(key_perm[4*j +: 4]);
				blk[j] = (p < n) ? plain_buf[p] : btc_pkg::PAD_BYTE;
			end
		end else begin
			for (j = 0; j < n; j++) begin
				blk[j] = btc_pkg::PAD_BYTE;
				hit[j] = 1'b0;
			end
			// inverse map; lowest entry wins on duplicates
			for (j = 0; j < n; j++) begin
				p = 32'(key_perm[4*j +: 4]);
				if (p < n && !hit[p]) begin
					blk[p] = plain_buf[j];
					hit[p] = 1'b1;
				end
			end
		end
		for (j = 0; j < n; j++) begin
			beat.data    = blk[j];
			beat.blk_end = (j + 1 == n);
			beat.msg_end = (j + 1 == n) && last;
			pending_cipher.push_back(beat);
		end
		plain_fill = 0;
		return n;
	endfunction

	// offer one byte with random gaps; predict on acceptance
	task automatic send_byte(input logic [btc_pkg::DATA_W-1:0] b, input logic last,
			output int unsigned n_res, output logic [btc_pkg::DATA_W-1:0] first);
		int unsigned old;
		while ($urandom_range(99) < send_idle_pct) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid       <= 1'b1;
		msg_if.in_byte     <= b;
		msg_if.message_end <= last;
		do @(posedge clk); while (!(msg_if.valid && msg_if.ready));
		old = pending_cipher.size();
		n_res = encipher_step(b, last);
		first = (n_res != 0) ? pending_cipher[old].data : '0;
		bytes_sent++;
	endtask

	// stop offering, let every cipher byte out, then let the core settle
	task automatic wait_drained();
		msg_if.valid <= 1'b0;
		do @(posedge clk); while (pending_cipher.size() != 0);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// APB write followed by a read back of the same register
	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
		logic [63:0] want;
		logic [63:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			btc_pkg::REG_MODE: begin
				key_mode = btc_pkg::mode_t'(val[0]);
				want = {63'd0, val[0]};
			end
			btc_pkg::REG_SIZE: begin
				key_size = val[btc_pkg::SIZE_W-1:0];
				want = {{(64-btc_pkg::SIZE_W){1'b0}}, val[btc_pkg::SIZE_W-1:0]};
			end
			default: begin
				key_perm = val;
				want = val;
			end
		endcase
		reg_writes++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			errors++;
			$display("%0t: register %0d read back expected %h, actual %h",
				$time, idx, want, got);
		end
		@(posedge clk);
	endtask

	// random settings, mostly true permutations of the active block
	task automatic shuffle_config();
		int unsigned                r, n, j, k, t;
		int unsigned                order [MAX_BLOCK];
		logic [btc_pkg::SIZE_W-1:0] size_val;
		logic [63:0]                perm_val;
		btc_pkg::mode_t             pick_mode;
		pick_mode = ($urandom_range(1) != 0) ? btc_pkg::MODE_DEC : btc_pkg::MODE_ENC;
		r = $urandom_range(99);
		if (r < 8)
			size_val = '0;
		else if (r < 16)
			size_val = btc_pkg::SIZE_W'($urandom_range(31, MAX_BLOCK + 1));
		else if (r < 30)
			size_val = btc_pkg::SIZE_W'(MAX_BLOCK);
		else if (r < 50)
			size_val = btc_pkg::SIZE_W'($urandom_range(3, 1));
		else
			size_val = btc_pkg::SIZE_W'($urandom_range(MAX_BLOCK, 1));
		n = (size_val == 0) ? 1 : (size_val > MAX_BLOCK) ? MAX_BLOCK : 32'(size_val);
		r = $urandom_range(99);
		perm_val = {$urandom, $urandom};
		if (r < 60) begin
			for (j = 0; j < MAX_BLOCK; j++)
				order[j] = j;
			for (j = n - 1; j > 0; j--) begin
				k = $urandom_range(j);
				t = order[j];
				order[j] = order[k];
				order[k] = t;
			end
			for (j = 0; j < n; j++)
				perm_val[4*j +: 4] = 4'(order[j]);
		end else if (r < 70)
			perm_val = btc_pkg::PERM_RESET;
		else if (r < 78)
			perm_val = '0;
		else if (r < 84)
			perm_val = '1;
		wait_drained();
		cfg_write(btc_pkg::REG_MODE, 64'(pick_mode));
		cfg_write(btc_pkg::REG_SIZE, 64'(size_val));
		cfg_write(btc_pkg::REG_PERM, perm_val);
	endtask

	// one message of random bytes; some run on into the next without an end
	task automatic send_message();
		int unsigned                len, i, r, n_res;
		logic [btc_pkg::DATA_W-1:0] b;
		logic [btc_pkg::DATA_W-1:0] first;
		bit                         open_end;
		len = $urandom_range(2 * block_len() + 2, 1);
		open_end = ($urandom_range(99) < 15);
		for (i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 12)
				b = btc_pkg::PERCENT_BYTE;
			else if (r < 20)
				b = btc_pkg::PAD_BYTE;
			else if (r < 24)
				b = 8'h00;
			else if (r < 28)
				b = 8'hFF;
			else
				b = 8'($urandom_range(255));
			send_byte(b, (i + 1 == len) && !open_end, n_res, first);
		end
		messages++;
	endtask

	// receiver: random stalls plus one long hold on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			cph_if.ready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack     <= hold_req;
			hold_left    <= LONG_STALL;
			cph_if.ready <= 1'b0;
		end else begin
			cph_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each cipher transaction with the oldest expected byte
	always @(posedge clk) begin
		cipher_beat_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && cph_if.valid && cph_if.ready) begin
			beats_checked++;
			if (pending_cipher.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: cipher byte expected none, actual %h/%b/%b", $time,
						cph_if.out_byte, cph_if.block_last, cph_if.message_last);
			end else begin
				want = pending_cipher.pop_front();
				if (cph_if.out_byte !== want.data || cph_if.block_last !== want.blk_end ||
						cph_if.message_last !== want.msg_end) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: cipher byte expected %h/%b/%b, actual %h/%b/%b",
							$time, want.data, want.blk_end, want.msg_end, cph_if.out_byte,
							cph_if.block_last, cph_if.message_last);
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < LIMIT)
			@(posedge clk);
		$display("%0t: timeout, %0d cipher bytes still expected", $time,
			pending_cipher.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned                ph, goal, n_res;
		logic [btc_pkg::DATA_W-1:0] first;
		bit                         pressure_done;
		pressure_done      = 1'b0;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		msg_if.valid       <= 1'b0;
		msg_if.in_byte     <= '0;
		msg_if.message_end <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted cases
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (script[i].kind == ROW_REG) begin
				wait_drained();
				cfg_write(script[i].reg_idx, script[i].value);
			end else begin
				send_byte(script[i].data, script[i].last, n_res, first);
				if (script[i].known && (n_res != script[i].known_count ||
						first !== script[i].known_first)) begin
					errors++;
					$display("%0t: row %0d expected %0d bytes led by %h, actual %0d led by %h",
						$time, i, script[i].known_count, script[i].known_first, n_res, first);
				end
			end
		end

		// random messages: both sides stalling, roles swapped, then no random stalls but one long output hold
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 77 : 0;
			recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 36 : 0;
			goal = bytes_sent + PHASE_BYTES;
			while (bytes_sent < goal) begin
				shuffle_config();
				if (ph == 2 && !pressure_done) begin
					hold_req <= ~hold_req;
					pressure_done = 1'b1;
				end
				repeat ($urandom_range(3, 1))
					send_message();
			end
		end

		wait_drained();
		$display("Covered %0d message bytes in %0d random messages, %0d register writes,",
			bytes_sent, messages, reg_writes);
		$display("%0d cipher bytes compared in encrypt and decrypt, sizes 0 to 31, with stalls.",
			beats_checked);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/btc_pkg.sv
rtl/core/btc_if.sv
rtl/core/btc_cfg_regs.sv
rtl/core/btc_perm_unit.sv
rtl/core/btc_engine.sv
rtl/core/block_transposition_cipher_core.sv
tb/testbench.sv
